// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the line-follow controller.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with its own message, switched off while reset is low.
`define LFSC_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Clocked assertion with a generic message.
`define LFSC_ASSERT(lbl, prop) `LFSC_ASSERT_MSG(lbl, prop, "lfsc assertion failed")

`endif

// ===== hw/rtl/lfsc_pkg.sv =====
// Types, codes and widths of the line-follow search controller.
// Used by every RTL file and the checker; depends on nothing.
`default_nettype none

package lfsc_pkg;

	localparam int TIMER_BITS = 16;
	localparam int WIN_BITS   = 16;
	localparam int CMP_BITS   = (TIMER_BITS > WIN_BITS) ? TIMER_BITS : WIN_BITS;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [WIN_BITS-1:0]   window_t;
	typedef logic [CMP_BITS-1:0]   cmp_t;
	typedef logic [2:0]            color_t;
	typedef logic [1:0]            drive_t;
	typedef logic [6:0]            speed_t;
	typedef logic [3:0]            laps_t;

	localparam timer_t TMAX = '1;
	localparam laps_t  LAPS_MAX = '1;

	typedef enum logic [2:0] {
		MODE_CAPTURE = 3'd0,
		MODE_FOLLOW  = 3'd1,
		MODE_CORRECT = 3'd2,
		MODE_SEARCH  = 3'd3,
		MODE_DONE    = 3'd4
	} mode_t;

	localparam drive_t DRIVE_STOP  = 2'd0;
	localparam drive_t DRIVE_FWD   = 2'd1;
	localparam drive_t DRIVE_LEFT  = 2'd2;
	localparam drive_t DRIVE_RIGHT = 2'd3;

	// Register indexes on the configuration port (byte address = 4 * index)
	localparam logic [2:0] REG_FOLLOW_SPEED  = 3'd0;
	localparam logic [2:0] REG_TRIM_SPEED    = 3'd1;
	localparam logic [2:0] REG_SWEEP_SPEED   = 3'd2;
	localparam logic [2:0] REG_CORRECT_WIN   = 3'd3;
	localparam logic [2:0] REG_SEARCH_WIN    = 3'd4;
	localparam logic [2:0] REG_RECENT_WIN    = 3'd5;
	localparam logic [2:0] REG_LAP_MIN       = 3'd6;
	localparam logic [2:0] REG_LAP_TARGET    = 3'd7;

	typedef struct packed {
		speed_t  follow_speed;
		speed_t  trim_speed;
		speed_t  sweep_speed;
		window_t correct_window;
		window_t search_window;
		window_t recent_window;
		window_t lap_min_samples;
		laps_t   lap_target;
	} cfg_t;

	typedef struct packed {
		logic   finished;
		laps_t  laps_done;
		speed_t speed;
		drive_t drive;
	} res_t;

	function automatic timer_t inc_sat(input timer_t t);
		return (t == TMAX) ? TMAX : timer_t'(t + timer_t'(1));
	endfunction

	function automatic drive_t side_cmd(input logic right);
		return right ? DRIVE_RIGHT : DRIVE_LEFT;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/line_follow_search_controller_unit.sv =====
// Top level of the line-follow search controller: stream ports, input and
// result registers, configuration port. Depends on lfsc_pkg, lfsc_regs, lfsc_core.
//
//   channel      | direction | handshake            | payload
//   -------------+-----------+----------------------+-------------------------------
//   s_axis       | in        | tvalid / tready      | tdata[2:0] color
//   m_axis       | out       | tvalid / tready      | tdata drive, speed, laps, finished
//   apb config   | in        | psel/penable/pready  | paddr[4:2] register, pwdata
//
// Each colour item passes an input register (_s1), one step of the state
// update, and a result register (_s2), one item per cycle sustained while
// m_axis does not stall. The controller state advances only when the item in the
// input register moves into the result register, so a stall on m_axis holds
// both stages and drops s_axis_tready once both are full. Reset clears the
// valid bits, the controller state and the registers to their defaults.
`default_nettype none

module line_follow_search_controller_unit (
	input  wire         clk,
	input  wire         arst_n,
	// slave stream: colour samples
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,  // [2:0] color, [7:3] zero
	// master stream: motor commands
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [1:0] drive, [8:2] speed, [12:9] laps_done,
	                                   // [13] finished, [15:14] zero
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lfsc_pkg::cfg_t   cfg;
	lfsc_pkg::res_t   res;

	logic             valid_s1;
	lfsc_pkg::color_t color_s1;
	logic             valid_s2;
	lfsc_pkg::res_t   res_s2;
	logic             adv_s2;   // result register can take a new item
	logic             step;     // item in the input register is processed now

	assign pready = 1'b1;

	lfsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Result register frees when empty or when its item is taken
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && adv_s2;
	// Input register frees when empty or when it hands its item on
	assign s_axis_tready = !valid_s1 || adv_s2;

	lfsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.color  (color_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register: hold the sample until the update consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			color_s1 <= s_axis_tdata[2:0];
		end
	end

	// Result register: load the updated command, hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2.finished, res_s2.laps_done,
		res_s2.speed, res_s2.drive};

endmodule

`default_nettype wire

// ===== hw/rtl/lfsc_regs.sv =====
// Configuration register file of the line-follow controller, APB-style port.
// Depends on lfsc_pkg.
`default_nettype none

module lfsc_regs (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [4:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output lfsc_pkg::cfg_t      cfg
);

	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.follow_speed    <= 7'd70;
			cfg.trim_speed      <= 7'd60;
			cfg.sweep_speed     <= 7'd70;
			cfg.correct_window  <= 16'd15;
			cfg.search_window   <= 16'd20;
			cfg.recent_window   <= 16'd10;
			cfg.lap_min_samples <= 16'd1000;
			cfg.lap_target      <= 4'd2;
		end else if (wr_en) begin
			case (idx)
				lfsc_pkg::REG_FOLLOW_SPEED:  cfg.follow_speed    <= pwdata[6:0];
				lfsc_pkg::REG_TRIM_SPEED:    cfg.trim_speed      <= pwdata[6:0];
				lfsc_pkg::REG_SWEEP_SPEED:   cfg.sweep_speed     <= pwdata[6:0];
				lfsc_pkg::REG_CORRECT_WIN:   cfg.correct_window  <= pwdata[15:0];
				lfsc_pkg::REG_SEARCH_WIN:    cfg.search_window   <= pwdata[15:0];
				lfsc_pkg::REG_RECENT_WIN:    cfg.recent_window   <= pwdata[15:0];
				lfsc_pkg::REG_LAP_MIN:       cfg.lap_min_samples <= pwdata[15:0];
				lfsc_pkg::REG_LAP_TARGET:    cfg.lap_target      <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			lfsc_pkg::REG_FOLLOW_SPEED:  prdata = 32'(cfg.follow_speed);
			lfsc_pkg::REG_TRIM_SPEED:    prdata = 32'(cfg.trim_speed);
			lfsc_pkg::REG_SWEEP_SPEED:   prdata = 32'(cfg.sweep_speed);
			lfsc_pkg::REG_CORRECT_WIN:   prdata = 32'(cfg.correct_window);
			lfsc_pkg::REG_SEARCH_WIN:    prdata = 32'(cfg.search_window);
			lfsc_pkg::REG_RECENT_WIN:    prdata = 32'(cfg.recent_window);
			lfsc_pkg::REG_LAP_MIN:       prdata = 32'(cfg.lap_min_samples);
			lfsc_pkg::REG_LAP_TARGET:    prdata = 32'(cfg.lap_target);
			default:                     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lfsc_core.sv =====
// Controller state and its one-sample update: mode, colours, timers, lap count.
// Depends on lfsc_pkg; the result shown is the state after the update.
`default_nettype none

module lfsc_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wire  [2:0]           color,
	input  lfsc_pkg::cfg_t       cfg,
	output lfsc_pkg::res_t       res
);

	lfsc_pkg::mode_t  mode_q, mode_d;
	lfsc_pkg::color_t bg_q, bg_d, start_q, start_d;
	logic             start_seen_q, start_seen_d;
	logic             right_q, right_d;
	lfsc_pkg::timer_t turn_q, turn_d, found_q, found_d, lap_q, lap_d;
	lfsc_pkg::laps_t  count_q, count_d;
	lfsc_pkg::drive_t drive_q, drive_d;
	lfsc_pkg::speed_t speed_q, speed_d;

	logic             on_line;
	logic             lap_hit;
	lfsc_pkg::timer_t found_inc, lap_inc, turn_inc, lap_eff;
	lfsc_pkg::color_t start_eff;

	assign on_line   = (color != bg_q);
	assign found_inc = lfsc_pkg::inc_sat(found_q);
	assign lap_inc   = start_seen_q ? lfsc_pkg::inc_sat(lap_q) : lap_q;
	assign turn_inc  = lfsc_pkg::inc_sat(turn_q);
	// A sample that first marks the start colour sees a cleared lap timer
	assign lap_eff   = start_seen_q ? lap_inc : '0;
	assign start_eff = start_seen_q ? start_q : color;
	assign lap_hit   = (color == start_eff) &&
		(lfsc_pkg::cmp_t'(lap_eff) >= lfsc_pkg::cmp_t'(cfg.lap_min_samples));

	always_comb begin
		mode_d       = mode_q;
		bg_d         = bg_q;
		start_d      = start_q;
		start_seen_d = start_seen_q;
		right_d      = right_q;
		turn_d       = turn_q;
		found_d      = found_q;
		lap_d        = lap_q;
		count_d      = count_q;
		drive_d      = drive_q;
		speed_d      = speed_q;
		case (mode_q)
			lfsc_pkg::MODE_CAPTURE: begin
				bg_d   = color;
				mode_d = lfsc_pkg::MODE_FOLLOW;
			end
			lfsc_pkg::MODE_FOLLOW: begin
				found_d = found_inc;
				lap_d   = lap_inc;
				if (on_line) begin
					start_seen_d = 1'b1;
					start_d      = start_eff;
					lap_d        = lap_eff;
					if (lap_hit) begin
						lap_d = '0;
						if (count_q != lfsc_pkg::LAPS_MAX)
							count_d = count_q + 4'd1;
					end
					if (count_d == cfg.lap_target) begin
						drive_d = lfsc_pkg::DRIVE_STOP;
						mode_d  = lfsc_pkg::MODE_DONE;
					end else begin
						drive_d = lfsc_pkg::DRIVE_FWD;
						speed_d = cfg.follow_speed;
					end
				end else begin
					if (lfsc_pkg::cmp_t'(found_inc) < lfsc_pkg::cmp_t'(cfg.recent_window))
						right_d = !right_q;
					drive_d = lfsc_pkg::side_cmd(right_d);
					speed_d = cfg.trim_speed;
					turn_d  = '0;
					mode_d  = lfsc_pkg::MODE_CORRECT;
				end
			end
			lfsc_pkg::MODE_CORRECT, lfsc_pkg::MODE_SEARCH: begin
				found_d = found_inc;
				lap_d   = lap_inc;
				if (on_line) begin
					drive_d = lfsc_pkg::DRIVE_STOP;
					found_d = '0;
					mode_d  = lfsc_pkg::MODE_FOLLOW;
				end else begin
					turn_d = turn_inc;
					if (mode_q == lfsc_pkg::MODE_CORRECT) begin
						if (lfsc_pkg::cmp_t'(turn_inc) >=
								lfsc_pkg::cmp_t'(cfg.correct_window)) begin
							right_d = !right_q;
							drive_d = lfsc_pkg::side_cmd(!right_q);
							speed_d = cfg.sweep_speed;
							turn_d  = '0;
							mode_d  = lfsc_pkg::MODE_SEARCH;
						end
					end else if (lfsc_pkg::cmp_t'(turn_inc) >=
							lfsc_pkg::cmp_t'(cfg.search_window)) begin
						mode_d = lfsc_pkg::MODE_FOLLOW;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= lfsc_pkg::MODE_CAPTURE;
			bg_q         <= '0;
			start_q      <= '0;
			start_seen_q <= 1'b0;
			right_q      <= 1'b0;
			turn_q       <= '0;
			found_q      <= lfsc_pkg::TMAX;
			lap_q        <= '0;
			count_q      <= '0;
			drive_q      <= lfsc_pkg::DRIVE_STOP;
			speed_q      <= '0;
		end else if (step) begin
			mode_q       <= mode_d;
			bg_q         <= bg_d;
			start_q      <= start_d;
			start_seen_q <= start_seen_d;
			right_q      <= right_d;
			turn_q       <= turn_d;
			found_q      <= found_d;
			lap_q        <= lap_d;
			count_q      <= count_d;
			drive_q      <= drive_d;
			speed_q      <= speed_d;
		end
	end

	assign res.drive     = drive_d;
	assign res.speed     = speed_d;
	assign res.laps_done = count_d;
	assign res.finished  = (mode_d == lfsc_pkg::MODE_DONE);

endmodule

`default_nettype wire

// ===== hw/rtl/lfsc_checker.sv =====
// Port-level checker for the line-follow controller, bound to the top level.
// Depends on lfsc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lfsc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata
);

	logic            fin_seen_q;
	lfsc_pkg::laps_t laps_q;
	logic            out_acc;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Track what earlier delivered items showed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_seen_q <= 1'b0;
			laps_q     <= '0;
		end else if (out_acc) begin
			fin_seen_q <= fin_seen_q || m_axis_tdata[13];
			laps_q     <= m_axis_tdata[12:9];
		end
	end

	// A stalled result holds
	`LFSC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// An empty result register never blocks the input side
	`LFSC_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready)

	// Finished items always carry a stop command
	`LFSC_ASSERT(a_finished_stops, m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[1:0] == lfsc_pkg::DRIVE_STOP)

	// Once finished, every later item stays finished with the same lap count
	`LFSC_ASSERT_MSG(a_finished_sticky, m_axis_tvalid && fin_seen_q |-> m_axis_tdata[13] && m_axis_tdata[12:9] == laps_q, "lfsc: finished state left")

	// The lap count never falls between delivered items
	`LFSC_ASSERT(a_laps_monotonic, m_axis_tvalid |-> m_axis_tdata[12:9] >= laps_q)

endmodule

bind line_follow_search_controller_unit lfsc_checker u_lfsc_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for line_follow_search_controller_unit: colour items in,
// motor commands out, with a behavioural predictor and random handshake idling.
// Depends on lfsc_pkg and the RTL of the unit only.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int DIR_N       = 22;
	localparam int RAND_ITEMS  = 135;
	localparam int LAST_ITEMS  = 80;

	// One directed row: colour, whether the command is typed in, and that command
	typedef struct packed {
		lfsc_pkg::color_t col;
		logic             typed;
		lfsc_pkg::res_t   want;
	} dir_row_t;

	// Background 7, start mark 0, other line colours 3 and 4.
	// Windows for this part: correct 3, search 2, lap minimum 3.
	localparam dir_row_t DIRECTED [DIR_N] = '{
		{3'd7, 1'b1, 1'b0, 4'd0, 7'd0,  lfsc_pkg::DRIVE_STOP},  // capture background
		{3'd0, 1'b1, 1'b0, 4'd0, 7'd70, lfsc_pkg::DRIVE_FWD},   // first line colour, start mark
		{3'd0, 1'b1, 1'b0, 4'd0, 7'd70, lfsc_pkg::DRIVE_FWD},
		{3'd7, 1'b0, 14'd0},                          // correction toward the left
		{3'd7, 1'b0, 14'd0},
		{3'd7, 1'b0, 14'd0},
		{3'd7, 1'b0, 14'd0},                          // correction times out, search right
		{3'd7, 1'b0, 14'd0},
		{3'd7, 1'b0, 14'd0},                          // search times out, turn kept
		{3'd7, 1'b0, 14'd0},                          // fresh correction, line long lost
		{3'd0, 1'b0, 14'd0},                          // found during correction
		{3'd7, 1'b0, 14'd0},                          // found recently: reverse side
		{3'd7, 1'b0, 14'd0},
		{3'd7, 1'b0, 14'd0},
		{3'd7, 1'b0, 14'd0},                          // into the search turn
		{3'd3, 1'b0, 14'd0},                          // found during search
		{3'd3, 1'b0, 14'd0},
		{3'd0, 1'b0, 14'd0},                          // start mark again: lap
		{3'd0, 1'b0, 14'd0},                          // too soon for another lap
		{3'd4, 1'b0, 14'd0},
		{3'd7, 1'b0, 14'd0},
		{3'd0, 1'b0, 14'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [2:0] color, [7:3] zero
	wire         m_axis_tvalid;
	logic        m_axis_tready;
	wire  [15:0] m_axis_tdata;   // [1:0] drive, [8:2] speed, [12:9] laps_done, [13] finished
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;

	line_follow_search_controller_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Predictor state and its copy of the registers
	lfsc_pkg::cfg_t   cfg;
	lfsc_pkg::mode_t  st_mode;
	lfsc_pkg::color_t bg_col;
	lfsc_pkg::color_t start_col;
	logic             start_seen;
	logic             on_right;
	lfsc_pkg::timer_t turn_t;
	lfsc_pkg::timer_t since_t;
	lfsc_pkg::timer_t lap_t;
	lfsc_pkg::laps_t  laps;
	lfsc_pkg::drive_t drv;
	lfsc_pkg::speed_t spd;

	lfsc_pkg::res_t   pending_cmds [$];

	int     n_items;
	int     n_checked;
	int     n_err;
	int     n_settings;
	int     cycle_cnt;
	int     tx_calm;
	int     rx_hold;
	int     rx_calm;
	logic   idle_en;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Saturating timer step
	function automatic lfsc_pkg::timer_t bump(input lfsc_pkg::timer_t t);
		return (t == '1) ? t : t + lfsc_pkg::timer_t'(1);
	endfunction

	// Advance the predictor by one colour item and return the motor command
	function automatic lfsc_pkg::res_t next_command(input lfsc_pkg::color_t c);
		logic           on_line;
		lfsc_pkg::res_t r;
		if (st_mode == lfsc_pkg::MODE_CAPTURE) begin
			bg_col  = c;
			st_mode = lfsc_pkg::MODE_FOLLOW;
		end else if (st_mode != lfsc_pkg::MODE_DONE) begin
			since_t = bump(since_t);
			if (start_seen)
				lap_t = bump(lap_t);
			on_line = (c != bg_col);
			if (st_mode == lfsc_pkg::MODE_FOLLOW) begin
				if (on_line) begin
					if (!start_seen) begin
						start_seen = 1'b1;
						start_col  = c;
						lap_t      = '0;
					end
					if (c == start_col && lap_t >= cfg.lap_min_samples) begin
						lap_t = '0;
						if (laps != '1)
							laps = laps + lfsc_pkg::laps_t'(1);
					end
					if (laps == cfg.lap_target) begin
						drv     = lfsc_pkg::DRIVE_STOP;
						st_mode = lfsc_pkg::MODE_DONE;
					end else begin
						drv = lfsc_pkg::DRIVE_FWD;
						spd = cfg.follow_speed;
					end
				end else begin
					// line seen only a moment ago: it lies on the other side
					if (since_t < cfg.recent_window)
						on_right = ~on_right;
					drv     = on_right ? lfsc_pkg::DRIVE_RIGHT : lfsc_pkg::DRIVE_LEFT;
					spd     = cfg.trim_speed;
					turn_t  = '0;
					st_mode = lfsc_pkg::MODE_CORRECT;
				end
			end else if (on_line) begin
				drv     = lfsc_pkg::DRIVE_STOP;
				since_t = '0;
				st_mode = lfsc_pkg::MODE_FOLLOW;
			end else begin
				turn_t = bump(turn_t);
				if (st_mode == lfsc_pkg::MODE_CORRECT) begin
					if (turn_t >= cfg.correct_window) begin
						on_right = ~on_right;
						drv      = on_right ? lfsc_pkg::DRIVE_RIGHT : lfsc_pkg::DRIVE_LEFT;
						spd      = cfg.sweep_speed;
						turn_t   = '0;
						st_mode  = lfsc_pkg::MODE_SEARCH;
					end
				end else if (turn_t >= cfg.search_window) begin
					st_mode = lfsc_pkg::MODE_FOLLOW;
				end
			end
		end
		r.drive     = drv;
		r.speed     = spd;
		r.laps_done = laps;
		r.finished  = (st_mode == lfsc_pkg::MODE_DONE);
		return r;
	endfunction

	// Any colour other than the background
	function automatic lfsc_pkg::color_t line_colour();
		lfsc_pkg::color_t c;
		do
			c = lfsc_pkg::color_t'($urandom_range(7));
		while (c == bg_col);
		return c;
	endfunction

	// Offer one colour item, with an optional idle burst first; predict on acceptance
	task automatic send_color(input lfsc_pkg::color_t c, input logic typed,
			input lfsc_pkg::res_t want);
		lfsc_pkg::res_t p;
		if (idle_en) begin
			if (tx_calm > 0) begin
				tx_calm--;
			end else if ($urandom_range(39) == 0) begin
				tx_calm = $urandom_range(60, 20);
			end else if ($urandom_range(6) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(14, 1)) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, c};
		do
			@(posedge clk);
		while (!s_axis_tready);
		p = next_command(c);
		pending_cmds.push_back(typed ? want : p);
		n_items++;
	endtask

	// Drop valid and hold until every predicted command has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	// Setup then access phase; the bus is left selected for a following write
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			lfsc_pkg::REG_FOLLOW_SPEED: cfg.follow_speed    = v[6:0];
			lfsc_pkg::REG_TRIM_SPEED:   cfg.trim_speed      = v[6:0];
			lfsc_pkg::REG_SWEEP_SPEED:  cfg.sweep_speed     = v[6:0];
			lfsc_pkg::REG_CORRECT_WIN:  cfg.correct_window  = v[15:0];
			lfsc_pkg::REG_SEARCH_WIN:   cfg.search_window   = v[15:0];
			lfsc_pkg::REG_RECENT_WIN:   cfg.recent_window   = v[15:0];
			lfsc_pkg::REG_LAP_MIN:      cfg.lap_min_samples = v[15:0];
			lfsc_pkg::REG_LAP_TARGET:   cfg.lap_target      = v[3:0];
			default: ;
		endcase
	endtask

	// Program all registers for one phase of the run
	task automatic setup_phase(input int ph);
		lfsc_pkg::speed_t  fs, cs, ss;
		lfsc_pkg::window_t cw, sw, rw, lm;
		lfsc_pkg::laps_t   tg;
		fs = lfsc_pkg::speed_t'($urandom_range(100));
		cs = lfsc_pkg::speed_t'($urandom_range(100));
		ss = lfsc_pkg::speed_t'($urandom_range(100));
		cw = lfsc_pkg::window_t'($urandom_range(8, 1));
		sw = lfsc_pkg::window_t'($urandom_range(8, 1));
		rw = lfsc_pkg::window_t'($urandom_range(12));
		lm = lfsc_pkg::window_t'($urandom_range(40, 5));
		tg = 4'd15;
		case (ph)
			0: begin
				// short windows so that every turn fits in the directed part
				fs = 7'd70; cs = 7'd60; ss = 7'd70;
				cw = 16'd3; sw = 16'd2; rw = 16'd10; lm = 16'd3;
			end
			1: begin
				fs = 7'd0; cs = 7'd0; ss = 7'd0;
				cw = 16'd1; sw = 16'd1; rw = 16'd0; lm = 16'd20;
			end
			2: begin
				// windows never expire, every correction reverses, laps on every mark
				fs = 7'd100; cs = 7'd100; ss = 7'd100;
				cw = '1; sw = '1; rw = '1; lm = 16'd0;
			end
			4: begin
				cw = 16'd0; sw = 16'd0; rw = 16'd1; lm = '1;
			end
			5: begin
				cw = lfsc_pkg::window_t'($urandom_range(20, 1));
				sw = lfsc_pkg::window_t'($urandom_range(20, 1));
				rw = lfsc_pkg::window_t'($urandom_range(30));
				lm = lfsc_pkg::window_t'($urandom_range(10));
			end
			7: begin
				cw = lfsc_pkg::window_t'($urandom_range(6, 1));
				sw = lfsc_pkg::window_t'($urandom_range(6, 1));
				rw = lfsc_pkg::window_t'($urandom_range(8));
				lm = 16'd3;
			end
			default: ;
		endcase
		// Keep the target out of reach until the last phase: a target below the
		// current count never matches, since the count only climbs.
		if (ph == 7) begin
			tg = (laps == '1) ? laps : laps + lfsc_pkg::laps_t'(1);
		end else if (ph != 0) begin
			if (laps != 0) begin
				tg = (ph == 2) ? lfsc_pkg::laps_t'(0) :
					lfsc_pkg::laps_t'($urandom_range(int'(laps) - 1));
			end else begin
				tg = 4'd15;
				if (lm < 16)
					lm = 16'd16;
			end
		end
		write_reg(lfsc_pkg::REG_FOLLOW_SPEED, 32'(fs));
		write_reg(lfsc_pkg::REG_TRIM_SPEED,   32'(cs));
		write_reg(lfsc_pkg::REG_SWEEP_SPEED,  32'(ss));
		write_reg(lfsc_pkg::REG_CORRECT_WIN,  32'(cw));
		write_reg(lfsc_pkg::REG_SEARCH_WIN,   32'(sw));
		write_reg(lfsc_pkg::REG_RECENT_WIN,   32'(rw));
		write_reg(lfsc_pkg::REG_LAP_MIN,      32'(lm));
		write_reg(lfsc_pkg::REG_LAP_TARGET,   32'(tg));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_settings++;
	endtask

	// Random runs of line, background and noise, sized to reach the timeouts
	task automatic run_random(input int n);
		int               left;
		int               len;
		int               kind;
		int               cap;
		int               k;
		lfsc_pkg::color_t c;
		left = n;
		while (left > 0) begin
			kind = $urandom_range(9);
			cap  = int'(cfg.correct_window) + int'(cfg.search_window) + 2;
			if (cap > 40)
				cap = 40;
			if (kind < 4)
				len = $urandom_range(12, 1);
			else if (kind < 8)
				len = $urandom_range(cap, 1);
			else
				len = $urandom_range(6, 1);
			if (len > left)
				len = left;
			for (k = 0; k < len; k++) begin
				if (kind < 4)
					c = (start_seen && $urandom_range(1) == 0) ? start_col : line_colour();
				else if (kind < 8)
					c = bg_col;
				else
					c = lfsc_pkg::color_t'($urandom_range(7));
				send_color(c, 1'b0, '0);
			end
			left -= len;
		end
	endtask

	// Receiver side: random stall bursts, calm stretches, none once idling is off
	always @(posedge clk) begin
		if (!idle_en) begin
			m_axis_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (rx_calm > 0) begin
			rx_calm--;
			m_axis_tready <= 1'b1;
		end else if ($urandom_range(49) == 0) begin
			rx_calm = $urandom_range(60, 20);
			m_axis_tready <= 1'b1;
		end else if ($urandom_range(7) == 0) begin
			rx_hold = $urandom_range(14, 1) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each accepted command with the oldest prediction
	always @(posedge clk) begin
		lfsc_pkg::res_t got;
		lfsc_pkg::res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = lfsc_pkg::res_t'(m_axis_tdata[13:0]);
			if (pending_cmds.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("Unexpected command: drive %0d speed %0d laps %0d finished %0b",
						got.drive, got.speed, got.laps_done, got.finished);
			end else begin
				want = pending_cmds.pop_front();
				n_checked++;
				if (got.drive !== want.drive || got.speed !== want.speed ||
				    got.laps_done !== want.laps_done || got.finished !== want.finished) begin
					n_err++;
					if (n_err <= 10)
						$display("Command %0d: expected drive %0d speed %0d laps %0d fin %0b, %s",
							n_checked, want.drive, want.speed, want.laps_done, want.finished,
							$sformatf("got drive %0d speed %0d laps %0d fin %0b",
								got.drive, got.speed, got.laps_done, got.finished));
				end
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d commands outstanding",
				cycle_cnt, pending_cmds.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		clk           = 1'b0;
		n_items = 0; n_checked = 0; n_err = 0; n_settings = 0; cycle_cnt = 0;
		tx_calm = 0; rx_hold = 0; rx_calm = 0;
		idle_en = 1'b1;

		// Predictor starts from the reset state and the register defaults
		cfg.follow_speed    = 7'd70;
		cfg.trim_speed      = 7'd60;
		cfg.sweep_speed     = 7'd70;
		cfg.correct_window  = 16'd15;
		cfg.search_window   = 16'd20;
		cfg.recent_window   = 16'd10;
		cfg.lap_min_samples = 16'd1000;
		cfg.lap_target      = 4'd2;
		st_mode    = lfsc_pkg::MODE_CAPTURE;
		bg_col     = '0;
		start_col  = '0;
		start_seen = 1'b0;
		on_right   = 1'b0;
		turn_t     = '0;
		since_t    = '1;
		lap_t      = '0;
		laps       = '0;
		drv        = lfsc_pkg::DRIVE_STOP;
		spd        = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through every turn, find and lap case
		setup_phase(0);
		for (i = 0; i < DIR_N; i++)
			send_color(DIRECTED[i].col, DIRECTED[i].typed, DIRECTED[i].want);
		drain();

		// Random phases over extreme and ordinary settings
		for (i = 1; i <= 6; i++) begin
			setup_phase(i);
			run_random(RAND_ITEMS);
			drain();
		end

		// Last phase: no idling, target reachable so the run can end stopped
		idle_en = 1'b0;
		setup_phase(7);
		run_random(LAST_ITEMS);
		drain();
		repeat (10) @(posedge clk);

		$display("Covered %0d colour items under %0d register settings, %0d commands checked",
			n_items, n_settings, n_checked);
		$display("Laps counted %0d, finished flag %0b at the end", laps,
			st_mode == lfsc_pkg::MODE_DONE);
		if (n_err == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatching or unexpected commands", n_err);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
